>>> rtl/ute_pkg.sv
// Shared types, constants and byte-forming helpers for the UTF-16/32 to UTF-8 encoder.
`default_nettype none

package ute_pkg;

  localparam int unsigned CpW   = 31;
  localparam int unsigned UnitW = 16;
  localparam int unsigned LenW  = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW = 1;
  localparam int unsigned QCntW = 2;

  localparam logic [15:0] SurMask   = 16'hFC00;
  localparam logic [15:0] HighBase  = 16'hD800;
  localparam logic [15:0] LowBase   = 16'hDC00;
  localparam logic [20:0] PlaneBase = 21'h10000;

  localparam logic        FormUtf32 = 1'b0;
  localparam logic        FormUtf16 = 1'b1;

  localparam logic [7:0]  ContTag   = 8'h80;
  localparam logic [7:0]  ThreeLead = 8'hE0;

  // one queued job: an optional lone held surrogate, then an optional code point
  typedef struct packed {
    logic                  pre_valid;
    logic [UnitW-1:0]      pre_cp;
    logic                  main_valid;
    logic [CpW-1:0]        main_cp;
    logic [LenW-1:0]       main_len;
  } job_t;

  function automatic logic [LenW-1:0] enc_len(input logic [CpW-1:0] cp);
    logic [LenW-1:0] len;
    if (cp < 31'h80)            len = 3'd1;
    else if (cp < 31'h800)      len = 3'd2;
    else if (cp < 31'h10000)    len = 3'd3;
    else if (cp < 31'h200000)   len = 3'd4;
    else if (cp < 31'h4000000)  len = 3'd5;
    else                        len = 3'd6;
    return len;
  endfunction

  function automatic logic [7:0] lead_prefix(input logic [LenW-1:0] len);
    logic [7:0] p;
    case (len)
      3'd2:    p = 8'hC0;
      3'd3:    p = 8'hE0;
      3'd4:    p = 8'hF0;
      3'd5:    p = 8'hF8;
      3'd6:    p = 8'hFC;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // 8-bit window of cp starting at bit 6*rem
  function automatic logic [7:0] cp_window(input logic [CpW-1:0] cp,
                                           input logic [LenW-1:0] rem);
    logic [7:0] w;
    case (rem)
      3'd0:    w = cp[7:0];
      3'd1:    w = cp[13:6];
      3'd2:    w = cp[19:12];
      3'd3:    w = cp[25:18];
      3'd4:    w = {1'b0, cp[30:24]};
      3'd5:    w = {7'b0, cp[30]};
      default: w = 8'h00;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ute_front.sv
// Front end: takes input beats, pairs surrogates and queues encode jobs.
`default_nettype none

module ute_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_data,
  input  wire logic                    in_valid,
  input  wire logic [ute_pkg::CpW-1:0] in_code_unit,
  input  wire logic                    in_last_unit,
  input  wire logic                    q_full,
  output logic                         push,
  output ute_pkg::job_t                push_job
);

  logic                      form_r, form_nxt;
  logic                      held_valid_r, held_valid_nxt;
  logic [ute_pkg::UnitW-1:0] held_high_r, held_high_nxt;

  logic                      accept;
  logic [ute_pkg::UnitW-1:0] unit;
  logic                      is_high, is_low;
  logic [20:0]               pair_cp;
  logic [ute_pkg::CpW-1:0]   main_cp;
  ute_pkg::job_t             job;

  assign accept  = in_valid && !q_full;
  assign unit    = in_code_unit[ute_pkg::UnitW-1:0];
  assign is_high = (unit & ute_pkg::SurMask) == ute_pkg::HighBase;
  assign is_low  = (unit & ute_pkg::SurMask) == ute_pkg::LowBase;
  assign pair_cp = ute_pkg::PlaneBase + {1'b0, held_high_r[9:0], unit[9:0]};

  always_comb begin
    form_nxt       = form_r;
    held_valid_nxt = held_valid_r;
    held_high_nxt  = held_high_r;
    main_cp        = in_code_unit;
    job            = '0;

    if (form_r == ute_pkg::FormUtf32) begin
      job.main_valid = 1'b1;
    end else if (held_valid_r && is_low) begin
      main_cp        = {10'b0, pair_cp};
      job.main_valid = 1'b1;
      held_valid_nxt = 1'b0;
    end else begin
      job.pre_valid  = held_valid_r;
      job.pre_cp     = held_high_r;
      main_cp        = {15'b0, unit};
      if (is_high && !in_last_unit) begin
        held_valid_nxt = 1'b1;
        held_high_nxt  = unit;
      end else begin
        job.main_valid = 1'b1;
        held_valid_nxt = 1'b0;
      end
    end
    job.main_cp  = main_cp;
    job.main_len = ute_pkg::enc_len(main_cp);

    if (!accept) begin
      held_valid_nxt = held_valid_r;
      held_high_nxt  = held_high_r;
    end
    if (cfg_we) begin
      form_nxt       = cfg_data;
      held_valid_nxt = 1'b0;
      held_high_nxt  = '0;
    end
  end

  assign push     = accept && (job.pre_valid || job.main_valid);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      form_r       <= ute_pkg::FormUtf32;
      held_valid_r <= 1'b0;
      held_high_r  <= '0;
    end else begin
      form_r       <= form_nxt;
      held_valid_r <= held_valid_nxt;
      held_high_r  <= held_high_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ute_queue.sv
// Two-entry job queue between the front end and the byte emitter.
`default_nettype none

module ute_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ute_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               pop_valid,
  output ute_pkg::job_t      pop_job
);

  ute_pkg::job_t                mem_r [ute_pkg::QueueDepth];
  logic [ute_pkg::QPtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [ute_pkg::QPtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [ute_pkg::QCntW-1:0]    count_r, count_nxt;

  assign full      = count_r == ute_pkg::QCntW'(ute_pkg::QueueDepth);
  assign pop_valid = count_r != '0;
  assign pop_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + ute_pkg::QCntW'(push) - ute_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ute_back.sv
// Back end: walks queued jobs and emits one UTF-8 byte per output beat.
`default_nettype none

module ute_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire ute_pkg::job_t  q_job,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          out_byte,
  output logic                out_last_of_item
);

  logic                         cur_active_r, cur_active_nxt;
  logic [ute_pkg::CpW-1:0]      cur_cp_r, cur_cp_nxt;
  logic [ute_pkg::LenW-1:0]     cur_rem_r, cur_rem_nxt;
  logic                         cur_first_r, cur_first_nxt;
  logic [7:0]                   cur_prefix_r, cur_prefix_nxt;
  logic                         cur_last_r, cur_last_nxt;
  logic                         pend_valid_r, pend_valid_nxt;
  logic [ute_pkg::CpW-1:0]      pend_cp_r, pend_cp_nxt;
  logic [ute_pkg::LenW-1:0]     pend_len_r, pend_len_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [7:0]                   out_byte_r, out_byte_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         advance, emit, cp_done;
  logic [7:0]                   win;

  assign advance = !out_valid_r || !out_stall;
  assign emit    = cur_active_r && advance;
  assign cp_done = emit && (cur_rem_r == '0);
  assign win     = ute_pkg::cp_window(cur_cp_r, cur_rem_r);
  // refill from the queue when idle or on the final byte of the last code point
  assign q_pop   = q_valid && (!cur_active_r || (cp_done && !pend_valid_r));

  always_comb begin
    cur_active_nxt = cur_active_r;
    cur_cp_nxt     = cur_cp_r;
    cur_rem_nxt    = cur_rem_r;
    cur_first_nxt  = cur_first_r;
    cur_prefix_nxt = cur_prefix_r;
    cur_last_nxt   = cur_last_r;
    pend_valid_nxt = pend_valid_r;
    pend_cp_nxt    = pend_cp_r;
    pend_len_nxt   = pend_len_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_first_r ? (cur_prefix_r | win) : (ute_pkg::ContTag | {2'b0, win[5:0]});
      out_last_nxt  = cp_done && cur_last_r;
      cur_first_nxt = 1'b0;
      cur_rem_nxt   = cur_rem_r - 1'b1;
    end else if (advance) begin
      out_valid_nxt = 1'b0;
    end

    if (cp_done) begin
      if (pend_valid_r) begin
        cur_cp_nxt     = pend_cp_r;
        cur_rem_nxt    = pend_len_r - 1'b1;
        cur_first_nxt  = 1'b1;
        cur_prefix_nxt = ute_pkg::lead_prefix(pend_len_r);
        cur_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
      end else begin
        cur_active_nxt = 1'b0;
      end
    end

    if (q_pop) begin
      cur_active_nxt = 1'b1;
      cur_first_nxt  = 1'b1;
      if (q_job.pre_valid) begin
        // lone held surrogate always encodes as three bytes
        cur_cp_nxt     = {15'b0, q_job.pre_cp};
        cur_rem_nxt    = 3'd2;
        cur_prefix_nxt = ute_pkg::ThreeLead;
        cur_last_nxt   = !q_job.main_valid;
        pend_valid_nxt = q_job.main_valid;
        pend_cp_nxt    = q_job.main_cp;
        pend_len_nxt   = q_job.main_len;
      end else begin
        cur_cp_nxt     = q_job.main_cp;
        cur_rem_nxt    = q_job.main_len - 1'b1;
        cur_prefix_nxt = ute_pkg::lead_prefix(q_job.main_len);
        cur_last_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_cp_r     <= cur_cp_nxt;
    cur_rem_r    <= cur_rem_nxt;
    cur_first_r  <= cur_first_nxt;
    cur_prefix_r <= cur_prefix_nxt;
    cur_last_r   <= cur_last_nxt;
    pend_cp_r    <= pend_cp_nxt;
    pend_len_r   <= pend_len_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_active_r <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cur_active_r <= cur_active_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last_of_item = out_last_r;

endmodule

`default_nettype wire

>>> rtl/utf16_to_utf8_encoder.sv
// Top level of the UTF-16/UTF-32 to UTF-8 encoder.
// Converts one code unit per input beat into its UTF-8 bytes, one byte per
// output beat, with out_last_of_item set on the final byte an input beat causes.
// cfg_data selects the input form (0: 31-bit code points, one to six bytes;
// 1: UTF-16 units, surrogate pairs become four bytes, a lone surrogate three).
// Write cfg only while idle; a write drops any held high surrogate. The output
// side runs at one byte per cycle unless out_stall holds it or no job is queued;
// an item has one to six bytes, and a held high surrogate yields none.
// Input beats are taken every cycle while the two-entry job queue has room.
`default_nettype none

module utf16_to_utf8_encoder (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [ute_pkg::CpW-1:0] in_code_unit,
  input  wire logic                    in_last_unit,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [7:0]                   out_byte,
  output logic                         out_last_of_item
);

  logic          q_push, q_full, q_pop, q_valid;
  ute_pkg::job_t push_job, pop_job;

  assign in_stall = q_full;

  ute_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_code_unit (in_code_unit),
    .in_last_unit (in_last_unit),
    .q_full       (q_full),
    .push         (q_push),
    .push_job     (push_job)
  );

  ute_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (pop_job)
  );

  ute_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_job            (pop_job),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item)
  );

`ifndef SYNTH
  a_job_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (pop_job.pre_valid || pop_job.main_valid))
    else $error("queued job carries no code point");

  a_pre_is_high: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && pop_job.pre_valid) |-> (pop_job.pre_cp[15:10] == 6'b110110))
    else $error("held unit released is not a high surrogate");

  a_ascii_len: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && pop_job.main_valid && pop_job.main_len == 3'd1) |->
      (pop_job.main_cp < 31'h80))
    else $error("single-byte job with a code point above ASCII");
`endif

endmodule

`default_nettype wire

>>> sim/utf8_checker.sv
// Checker for the UTF-8 encoder: predicts the byte stream from accepted units and compares.
module utf8_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [30:0] in_code_unit,
  input  logic        in_last_unit,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_last_of_item,
  output int          mismatches,
  output int          pending_beats
);

  typedef struct packed {
    logic [7:0] data;
    logic       tail;
  } utf8_beat_t;

  utf8_beat_t  expected_bytes[$];
  logic        form = ute_pkg::FormUtf32;
  logic [15:0] held_unit = '0;
  logic        held_ok = 1'b0;
  int          errs = 0;

  // original (up to six byte) UTF-8 layout
  function automatic void append_utf8(input logic [30:0] cp);
    logic [7:0]  cont [6];
    logic [30:0] v;
    logic [30:0] head;
    logic [7:0]  lead;
    utf8_beat_t  b;
    int          k;
    v    = cp;
    head = 31'h3F;
    lead = 8'h80;
    k    = 0;
    b.tail = 1'b0;
    if (v < 31'h80) begin
      b.data = v[7:0];
      expected_bytes.push_back(b);
      return;
    end
    while (v > head && k < 5) begin
      cont[k] = ute_pkg::ContTag | {2'b00, v[5:0]};
      lead    = 8'h80 | (lead >> 1);
      head    = head >> 1;
      v       = v >> 6;
      k++;
    end
    b.data = lead | v[7:0];
    expected_bytes.push_back(b);
    while (k > 0) begin
      k--;
      b.data = cont[k];
      expected_bytes.push_back(b);
    end
  endfunction

  function automatic void predict_unit(input logic [30:0] cu, input logic last);
    int          start_size;
    logic [15:0] u;
    logic        is_high;
    logic        is_low;
    utf8_beat_t  b;
    start_size = expected_bytes.size();
    u       = cu[15:0];
    is_high = (u & ute_pkg::SurMask) == ute_pkg::HighBase;
    is_low  = (u & ute_pkg::SurMask) == ute_pkg::LowBase;
    if (form == ute_pkg::FormUtf32) begin
      append_utf8(cu);
    end else if (held_ok && is_low) begin
      append_utf8({10'b0, ute_pkg::PlaneBase} + {11'b0, held_unit[9:0], u[9:0]});
      held_ok = 1'b0;
    end else begin
      // a held surrogate with no low partner goes out on its own
      if (held_ok) begin
        append_utf8({15'b0, held_unit});
        held_ok = 1'b0;
      end
      if (is_high && !last) begin
        held_unit = u;
        held_ok   = 1'b1;
      end else begin
        append_utf8({15'b0, u});
      end
    end
    if (expected_bytes.size() > start_size) begin
      b = expected_bytes.pop_back();
      b.tail = 1'b1;
      expected_bytes.push_back(b);
    end
  endfunction

  always @(posedge clk) begin
    utf8_beat_t want;
    utf8_beat_t got;
    if (!rst_n) begin
      expected_bytes.delete();
      form    = ute_pkg::FormUtf32;
      held_ok = 1'b0;
    end else begin
      if (cfg_we) begin
        form      = cfg_data;
        held_ok   = 1'b0;
        held_unit = '0;
      end
      if (in_valid && !in_stall)
        predict_unit(in_code_unit, in_last_unit);
      if (out_valid && !out_stall) begin
        got.data = out_byte;
        got.tail = out_last_of_item;
        if (expected_bytes.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: byte %h last %b arrived with nothing outstanding",
                     $realtime, got.data, got.tail);
        end else begin
          want = expected_bytes.pop_front();
          if (want != got) begin
            errs++;
            if (errs <= 10)
              $display("%0t: byte exp %h got %h, last exp %b got %b", $realtime,
                       want.data, got.data, want.tail, got.tail);
          end
        end
      end
    end
    pending_beats <= expected_bytes.size();
    mismatches    <= errs;
  end

endmodule

>>> sim/tb_top.sv
// Top of the encoder testbench: clock, reset, unit stimulus, pacing and verdict.
module tb_top;

  localparam int QuietLimit   = 2000;
  localparam int SettleCycles = 12;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic                      cfg_data = ute_pkg::FormUtf32;
  logic                      in_valid = 1'b0;
  logic [ute_pkg::CpW-1:0]   in_code_unit = '0;
  logic                      in_last_unit = 1'b0;
  logic                      out_stall = 1'b0;
  logic                      in_stall;
  logic                      out_valid;
  logic [7:0]                out_byte;
  logic                      out_last_of_item;
  logic                      calm = 1'b0;
  int                        rcv_wait = 0;
  int                        quiet = 0;
  int                        mismatches;
  int                        pending_beats;

  always #1 clk = ~clk;

  utf16_to_utf8_encoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_code_unit     (in_code_unit),
    .in_last_unit     (in_last_unit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item)
  );

  utf8_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_code_unit     (in_code_unit),
    .in_last_unit     (in_last_unit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item),
    .mismatches       (mismatches),
    .pending_beats    (pending_beats)
  );

  // mostly short waits, now and then a long one; none while calm
  function automatic int pick_wait();
    if (calm)
      return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : $urandom_range(0, 2);
  endfunction

  // receiver: after each beat, hold stall for a wait drawn by pick_wait
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rcv_wait  <= 0;
    end else if (out_valid && !out_stall) begin
      w = pick_wait();
      rcv_wait  <= w;
      out_stall <= (w > 0);
    end else if (rcv_wait > 0) begin
      rcv_wait  <= rcv_wait - 1;
      out_stall <= (rcv_wait > 1);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("FAIL utf16_to_utf8_encoder");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [ute_pkg::CpW-1:0] cu, input logic last);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_code_unit <= cu;
    in_last_unit <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // upper bits are don't-care in UTF-16 form; scramble them now and then
  task automatic send_unit16(input logic [15:0] u, input logic last);
    logic [14:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? 15'($urandom()) : 15'h0;
    send_beat({junk, u}, last);
  endtask

  task automatic send_random_cp();
    int          cls;
    logic [30:0] lo [6];
    logic [30:0] hi [6];
    lo = '{31'h0, 31'h80, 31'h800, 31'h10000, 31'h200000, 31'h4000000};
    hi = '{31'h7F, 31'h7FF, 31'hFFFF, 31'h1FFFFF, 31'h3FFFFFF, 31'h7FFFFFFF};
    cls = $urandom_range(0, 5);
    send_beat(31'($urandom_range(hi[cls], lo[cls])), 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_form(input logic f);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= f;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [15:0] rand_high();
    return ute_pkg::HighBase | 16'($urandom_range(0, 10'h3FF));
  endfunction

  function automatic logic [15:0] rand_low();
    return ute_pkg::LowBase | 16'($urandom_range(0, 10'h3FF));
  endfunction

  function automatic logic [15:0] rand_bmp();
    logic [15:0] u;
    u = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 16'h7FF))
                                    : 16'($urandom_range(0, 16'hFFFF));
    if ((u & 16'hF800) == ute_pkg::HighBase)
      u = u ^ 16'h4000;
    return u;
  endfunction

  initial begin
    int sent;
    int kind;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // code point form straight out of reset: zero, then the top of each length class
    send_beat(31'h0, 1'b0);
    send_beat(31'h7F, 1'b1);
    send_beat(31'h7FF, 1'b0);
    send_beat(31'hFFFF, 1'b0);
    send_beat(31'h1FFFFF, 1'b1);
    send_beat(31'h3FFFFFF, 1'b0);
    send_beat(31'h7FFFFFFF, 1'b1);

    write_form(ute_pkg::FormUtf16);
    send_unit16(ute_pkg::HighBase, 1'b0);            // held, no bytes
    send_unit16(ute_pkg::LowBase, 1'b1);             // smallest pair
    send_unit16(ute_pkg::HighBase | 16'h3FF, 1'b0);
    send_unit16(ute_pkg::LowBase | 16'h3FF, 1'b0);   // largest pair
    send_unit16(ute_pkg::HighBase, 1'b1);            // high flagged last: alone
    send_unit16(ute_pkg::LowBase, 1'b0);             // lone low
    send_unit16(ute_pkg::HighBase | 16'h12, 1'b0);
    send_unit16(16'h0041, 1'b0);                     // held released, then ASCII
    send_unit16(ute_pkg::HighBase, 1'b0);
    send_unit16(ute_pkg::HighBase | 16'h3FF, 1'b0);  // release first, hold second
    send_unit16(16'h0000, 1'b0);                     // release second, then zero byte
    send_unit16(ute_pkg::HighBase | 16'h1, 1'b0);
    send_unit16(ute_pkg::HighBase | 16'h2, 1'b1);    // six bytes from one beat
    send_beat(31'h7FFF0041, 1'b0);
    send_beat(31'h1234D800, 1'b0);
    send_beat(31'h5678DC00, 1'b1);
    send_unit16(ute_pkg::HighBase | 16'h155, 1'b0);  // left held across the form write

    write_form(ute_pkg::FormUtf32);
    calm <= 1'b1;
    for (int i = 0; i < 25; i++) begin
      if ($urandom_range(0, 14) == 0)
        calm <= ~calm;
      send_random_cp();
    end

    write_form(ute_pkg::FormUtf16);
    calm <= 1'b0;
    sent = 0;
    while (sent < 60) begin
      if ($urandom_range(0, 19) == 0)
        calm <= ~calm;
      if (sent >= 30 && sent < 33)
        drain();
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        send_unit16(rand_bmp(), 1'($urandom_range(0, 7) == 0));
        sent += 1;
      end else if (kind <= 6) begin
        send_unit16(rand_high(), 1'b0);
        send_unit16(rand_low(), 1'($urandom_range(0, 3) == 0));
        sent += 2;
      end else if (kind == 7) begin
        send_unit16(rand_high(), 1'($urandom_range(0, 1)));
        sent += 1;
      end else if (kind == 8) begin
        send_unit16(rand_low(), 1'($urandom_range(0, 1)));
        sent += 1;
      end else begin
        send_unit16(rand_high(), 1'b0);
        send_unit16(rand_high(), 1'($urandom_range(0, 1)));
        sent += 2;
      end
    end
    send_unit16(rand_bmp(), 1'b1);

    write_form(ute_pkg::FormUtf32);
    calm <= 1'b0;
    for (int i = 0; i < 10; i++)
      send_random_cp();

    drain();
    if (mismatches == 0 && pending_beats == 0)
      $display("PASS utf16_to_utf8_encoder");
    else
      $display("FAIL utf16_to_utf8_encoder");
    $finish;
  end

endmodule
